// ----- hw/rtl/i2crf_pkg.sv -----
package i2crf_pkg;

   // register store geometry
   localparam int unsigned NUM_REGS = 768;
   localparam int unsigned ADDR_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   // special addresses and masks
   localparam logic [15:0] SEQ_STATUS_ADDR = 16'h005D;
   localparam logic [15:0] SEQ_BUSY_MASK   = 16'h0001;

   // item command codes
   localparam logic [1:0] CMD_START_WR = 2'd0;
   localparam logic [1:0] CMD_START_RD = 2'd1;
   localparam logic [1:0] CMD_BYTE_WR  = 2'd2;
   localparam logic [1:0] CMD_BYTE_RD  = 2'd3;

   // write transaction phases
   localparam logic [1:0] PH_ADDR_HI = 2'd0;
   localparam logic [1:0] PH_ADDR_LO = 2'd1;
   localparam logic [1:0] PH_DATA_HI = 2'd2;
   localparam logic [1:0] PH_DATA_LO = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic clear_step;   // write zero at the clear counter, advance it
      logic capture;      // latch the item and read the word at the pointer
      logic exec;         // apply the item, load the result
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;   // clear counter is at the last entry
   } dp_status_type;

endpackage

// ----- hw/rtl/i2crf_ctrl.sv -----
module i2crf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output i2crf_pkg::dp_cmd_type    dp_cmd,
   input  i2crf_pkg::dp_status_type dp_status
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            dp_cmd.exec = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = reset | (state_ff != ST_IDLE);

endmodule

// ----- hw/rtl/i2crf_datapath.sv -----
module i2crf_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_cmd,
   input  logic [7:0]               req_byte_in,
   input  i2crf_pkg::dp_cmd_type     dp_cmd,
   output i2crf_pkg::dp_status_type  dp_status,
   output logic [7:0]               rsp_read_byte,
   output logic                     rsp_read_valid,
   output logic                     rsp_strobe
);

   // register store
   logic [15:0] mem [i2crf_pkg::NUM_REGS];

   logic [i2crf_pkg::ADDR_W-1:0] clr_cnt_ff;
   logic [i2crf_pkg::ADDR_W-1:0] clr_cnt_in;

   logic [15:0] ptr_ff, ptr_in;
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  pend_ff, pend_in;
   logic        low_next_ff, low_next_in;

   logic [1:0]  cmd_ff;
   logic [7:0]  byte_ff;
   logic [15:0] rd_data_ff;

   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_strobe_ff;

   logic                         in_range;
   logic [15:0]                  word;
   logic                         mem_we;
   logic [i2crf_pkg::ADDR_W-1:0] mem_addr;
   logic [15:0]                  mem_wdata;

   assign in_range = {1'b0, ptr_ff} < 17'(i2crf_pkg::NUM_REGS);

   // clearing pass counter
   assign dp_status.clear_last =
      (clr_cnt_ff == i2crf_pkg::ADDR_W'(i2crf_pkg::NUM_REGS - 1));
   assign clr_cnt_in = dp_status.clear_last ? '0 : clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (dp_cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // fetched word, out of range reads zero, busy bit masked at status address
   always_comb begin
      word = in_range ? rd_data_ff : 16'h0000;
      if (ptr_ff == i2crf_pkg::SEQ_STATUS_ADDR) begin
         word = word & ~i2crf_pkg::SEQ_BUSY_MASK;
      end
   end

   // item execution
   always_comb begin
      ptr_in       = ptr_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      low_next_in  = low_next_ff;
      rsp_byte_in  = 8'h00;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = ptr_ff[i2crf_pkg::ADDR_W-1:0];
      mem_wdata    = {pend_ff, byte_ff};
      if (dp_cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_addr  = clr_cnt_ff;
         mem_wdata = 16'h0000;
      end else if (dp_cmd.exec) begin
         case (cmd_ff)
            i2crf_pkg::CMD_START_WR: begin
               phase_in = i2crf_pkg::PH_ADDR_HI;
            end
            i2crf_pkg::CMD_START_RD: begin
               low_next_in = 1'b0;
            end
            i2crf_pkg::CMD_BYTE_WR: begin
               case (phase_ff)
                  i2crf_pkg::PH_ADDR_HI: begin
                     ptr_in   = {byte_ff, 8'h00};
                     phase_in = i2crf_pkg::PH_ADDR_LO;
                  end
                  i2crf_pkg::PH_ADDR_LO: begin
                     ptr_in   = {ptr_ff[15:8], ptr_ff[7:0] | byte_ff};
                     phase_in = i2crf_pkg::PH_DATA_HI;
                  end
                  i2crf_pkg::PH_DATA_HI: begin
                     pend_in  = byte_ff;
                     phase_in = i2crf_pkg::PH_DATA_LO;
                  end
                  default: begin
                     mem_we   = in_range;
                     ptr_in   = ptr_ff + 16'd1;
                     phase_in = i2crf_pkg::PH_DATA_HI;
                  end
               endcase
            end
            default: begin
               rsp_valid_in = 1'b1;
               if (low_next_ff) begin
                  rsp_byte_in = word[7:0];
                  low_next_in = 1'b0;
                  ptr_in      = ptr_ff + 16'd1;
               end else begin
                  rsp_byte_in = word[15:8];
                  low_next_in = 1'b1;
               end
            end
         endcase
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         rd_data_ff <= mem[ptr_ff[i2crf_pkg::ADDR_W-1:0]];
         cmd_ff     <= req_cmd;
         byte_ff    <= req_byte_in;
      end
   end

   // transaction state
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         phase_ff    <= i2crf_pkg::PH_ADDR_HI;
         pend_ff     <= '0;
         low_next_ff <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         phase_ff    <= phase_in;
         pend_ff     <= pend_in;
         low_next_ff <= low_next_in;
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dp_cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         rsp_byte_ff  <= rsp_byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_read_valid = rsp_valid_ff;
   assign rsp_strobe     = rsp_strobe_ff;

endmodule

// ----- hw/rtl/i2c_register_file_16bit_addr.sv -----
// Byte-level I2C target register file, 768 x 16-bit words, 16-bit addresses.
// An item (req_cmd, req_byte_in) is taken when start is high and busy is low.
// Every item gives exactly one result, shown on rsp_read_byte/rsp_read_valid
// for a single cycle with rsp_strobe high, once the item has passed the capture
// and result registers; the result cannot be held off, so the receiver must take it then.
// Each item first reads the word at the address pointer from the synchronous
// store and then applies the item, so busy is low again in the cycle after that
// and the block takes no new item before it is through with the last one.
// After reset the store is cleared one word per cycle, which keeps busy high
// until all 768 registers are cleared.
module i2c_register_file_16bit_addr (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_byte_in,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_read_valid,
   output logic       rsp_strobe
);

   i2crf_pkg::dp_cmd_type    dp_cmd;
   i2crf_pkg::dp_status_type dp_status;

   i2crf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   i2crf_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_byte_in    (req_byte_in),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_read_valid (rsp_read_valid),
      .rsp_strobe     (rsp_strobe)
   );

endmodule

// ----- hw/rtl/i2crf_checker.sv -----
module i2crf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_read_valid,
   input logic       rsp_strobe
);

   // clearing pass follows reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy) else $error("not busy after reset");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");

   // every result comes from an accepted item
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2)) else $error("stray result");

   // results are single-cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result repeated");

   // non-read results carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_read_valid) |-> (rsp_read_byte == 8'h00))
      else $error("nonzero byte without read");

endmodule

bind i2c_register_file_16bit_addr i2crf_checker u_i2crf_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import i2crf_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1450;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;

   // one bus event waiting to be driven, with the idle cycles before it
   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  data;
      int unsigned gap;
   } bus_item_t;

   // expected read return for one item
   typedef struct {
      logic [7:0] rbyte;
      logic       valid;
   } read_return_t;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       start       = 1'b0;
   logic [1:0] req_cmd     = CMD_START_WR;
   logic [7:0] req_byte_in = 8'h00;
   logic       busy;
   logic [7:0] rsp_read_byte;
   logic       rsp_read_valid;
   logic       rsp_strobe;

   bus_item_t    bus_item_q[$];
   read_return_t read_return_q[$];

   // shadow copy of the target's state
   logic [15:0] shadow_regs [NUM_REGS];
   logic [15:0] shadow_ptr;
   logic [1:0]  shadow_phase;
   logic [7:0]  shadow_msb;
   logic        shadow_rd_lo;

   int unsigned idle_pct;
   int unsigned queued_items;
   int unsigned hold_left;
   logic        gap_armed;
   int unsigned quiet_cycles;
   logic        timed_out;
   int unsigned err_count;
   int unsigned items_taken;
   int unsigned reads_checked;
   int unsigned words_stored;
   int unsigned words_dropped;

   i2c_register_file_16bit_addr DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_byte_in    (req_byte_in),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_read_valid (rsp_read_valid),
      .rsp_strobe     (rsp_strobe)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // advance the shadow state by one bus event, return what a read gives
   function automatic read_return_t apply_bus_event(logic [1:0] cmd, logic [7:0] data);
      read_return_t ret;
      logic [15:0]  word;
      ret.rbyte = 8'h00;
      ret.valid = 1'b0;
      case (cmd)
         CMD_START_WR: shadow_phase = PH_ADDR_HI;
         CMD_START_RD: shadow_rd_lo = 1'b0;
         CMD_BYTE_WR: begin
            case (shadow_phase)
               PH_ADDR_HI: begin
                  shadow_ptr   = {data, 8'h00};
                  shadow_phase = PH_ADDR_LO;
               end
               // OR, not replace: reads in between may have moved the pointer
               PH_ADDR_LO: begin
                  shadow_ptr   = shadow_ptr | {8'h00, data};
                  shadow_phase = PH_DATA_HI;
               end
               PH_DATA_HI: begin
                  shadow_msb   = data;
                  shadow_phase = PH_DATA_LO;
               end
               default: begin
                  if (shadow_ptr < NUM_REGS) begin
                     shadow_regs[shadow_ptr] = {shadow_msb, data};
                     words_stored++;
                  end else begin
                     words_dropped++;
                  end
                  shadow_ptr   = shadow_ptr + 16'd1;
                  shadow_phase = PH_DATA_HI;
               end
            endcase
         end
         default: begin
            word = (shadow_ptr < NUM_REGS) ? shadow_regs[shadow_ptr] : 16'h0000;
            if (shadow_ptr == SEQ_STATUS_ADDR)
               word = word & ~SEQ_BUSY_MASK;
            if (!shadow_rd_lo) begin
               ret.rbyte    = word[15:8];
               shadow_rd_lo = 1'b1;
            end else begin
               ret.rbyte    = word[7:0];
               shadow_rd_lo = 1'b0;
               shadow_ptr   = shadow_ptr + 16'd1;
            end
            ret.valid = 1'b1;
         end
      endcase
      return ret;
   endfunction

   // queue one item; its idle gap follows the idling of the current phase
   task automatic add_item(logic [1:0] cmd, logic [7:0] data);
      bus_item_t it;
      it.cmd  = cmd;
      it.data = data;
      it.gap  = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
      bus_item_q.push_back(it);
      queued_items++;
   endtask

   // start of write, address, then word pairs, optionally a lone data MSB
   task automatic add_write_txn(logic [15:0] addr, int unsigned nwords, logic trailing);
      add_item(CMD_START_WR, 8'($urandom));
      add_item(CMD_BYTE_WR, addr[15:8]);
      add_item(CMD_BYTE_WR, addr[7:0]);
      repeat (2 * nwords) add_item(CMD_BYTE_WR, 8'($urandom));
      if (trailing)
         add_item(CMD_BYTE_WR, 8'($urandom));
   endtask

   task automatic add_read_txn(int unsigned nbytes);
      add_item(CMD_START_RD, 8'($urandom));
      repeat (nbytes) add_item(CMD_BYTE_RD, 8'($urandom));
   endtask

   // addresses cluster where reads can see earlier writes and at the edges
   function automatic logic [15:0] pick_addr();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return 16'h0050 + 16'($urandom_range(31));
         5, 6:          return 16'h02F8 + 16'($urandom_range(15));
         7:             return 16'hFFFC + 16'($urandom_range(3));
         8:             return 16'($urandom);
         default:       return 16'($urandom_range(15));
      endcase
   endfunction

   // driver: take the item at the handshake, present the next after its gap
   always @(posedge clock) begin
      bus_item_t nxt;
      logic      present;
      if (reset) begin
         start <= 1'b0;
      end else begin
         present = start;
         if (start && !busy) begin
            read_return_q.push_back(apply_bus_event(req_cmd, req_byte_in));
            items_taken++;
            present = 1'b0;
         end
         if (!present && bus_item_q.size() > 0) begin
            if (!gap_armed) begin
               hold_left = bus_item_q[0].gap;
               gap_armed = 1'b1;
            end
            if (hold_left > 0) begin
               hold_left--;
            end else begin
               nxt = bus_item_q.pop_front();
               req_cmd     <= nxt.cmd;
               req_byte_in <= nxt.data;
               present   = 1'b1;
               gap_armed = 1'b0;
            end
         end
         start <= present;
      end
   end

   // monitor: every strobe is checked against the oldest expectation
   always @(posedge clock) begin
      read_return_t exp_ret;
      if (!reset && rsp_strobe) begin
         if (read_return_q.size() == 0) begin
            $display("%0t: result with nothing expected: read_byte=%h read_valid=%b",
                     $time, rsp_read_byte, rsp_read_valid);
            err_count++;
         end else begin
            exp_ret = read_return_q.pop_front();
            if (rsp_read_byte !== exp_ret.rbyte) begin
               $display("%0t: read_byte mismatch: expected %h, actual %h",
                        $time, exp_ret.rbyte, rsp_read_byte);
               err_count++;
            end
            if (rsp_read_valid !== exp_ret.valid) begin
               $display("%0t: read_valid mismatch: expected %b, actual %b",
                        $time, exp_ret.valid, rsp_read_valid);
               err_count++;
            end
            if (exp_ret.valid)
               reads_checked++;
         end
      end
   end

   // watchdog: too long without any handshake or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT)
         timed_out <= 1'b1;
   end

   initial begin
      int unsigned directed_items;
      int unsigned phase;
      int unsigned choice;
      int unsigned nbytes;

      timed_out     = 1'b0;
      gap_armed     = 1'b0;
      hold_left     = 0;
      quiet_cycles  = 0;
      err_count     = 0;
      items_taken   = 0;
      reads_checked = 0;
      words_stored  = 0;
      words_dropped = 0;
      queued_items  = 0;
      idle_pct      = 0;
      for (int i = 0; i < NUM_REGS; i++)
         shadow_regs[i] = 16'h0000;
      shadow_ptr   = 16'h0000;
      shadow_phase = PH_ADDR_HI;
      shadow_msb   = 8'h00;
      shadow_rd_lo = 1'b0;

      // directed: reads with no start right after reset
      add_item(CMD_BYTE_RD, 8'hFF);
      add_item(CMD_BYTE_RD, 8'h00);
      // all ones into the sequencer status, read back with bit 0 cleared
      add_item(CMD_START_WR, 8'hA5);
      add_item(CMD_BYTE_WR, 8'h00);
      add_item(CMD_BYTE_WR, 8'h5D);
      add_item(CMD_BYTE_WR, 8'hFF);
      add_item(CMD_BYTE_WR, 8'hFF);
      add_item(CMD_START_WR, 8'h5A);
      add_item(CMD_BYTE_WR, 8'h00);
      add_item(CMD_BYTE_WR, 8'h5D);
      add_item(CMD_START_RD, 8'hFF);
      add_item(CMD_BYTE_RD, 8'h00);
      add_item(CMD_BYTE_RD, 8'hFF);
      // top address: dropped write, pointer wraps to zero, then a lone MSB
      add_item(CMD_START_WR, 8'h00);
      add_item(CMD_BYTE_WR, 8'hFF);
      add_item(CMD_BYTE_WR, 8'hFF);
      add_item(CMD_BYTE_WR, 8'hAB);
      add_item(CMD_BYTE_WR, 8'hCD);
      add_item(CMD_BYTE_WR, 8'h80);
      // new start of write discards the lone MSB; last in-range register
      add_item(CMD_START_WR, 8'hFF);
      add_item(CMD_BYTE_WR, 8'h02);
      add_item(CMD_BYTE_WR, 8'hFF);
      add_item(CMD_BYTE_WR, 8'h01);
      add_item(CMD_BYTE_WR, 8'hFE);
      add_item(CMD_START_RD, 8'h00);
      add_item(CMD_BYTE_RD, 8'hFF);
      add_item(CMD_BYTE_RD, 8'h00);
      directed_items = queued_items;

      // random: mostly well-formed transactions, some broken ones and noise
      while (queued_items - directed_items < RANDOM_ITEMS) begin
         phase = ((queued_items - directed_items) * 4) / RANDOM_ITEMS;
         case (phase)
            1:       idle_pct = 78;
            3:       idle_pct = 18;
            default: idle_pct = 0;
         endcase
         choice = $urandom_range(99);
         if (choice < 40) begin
            add_write_txn(pick_addr(), $urandom_range(1, 4), $urandom_range(9) == 0);
         end else if (choice < 80) begin
            if ($urandom_range(3) != 0)
               add_write_txn(pick_addr(), 0, 1'b0);
            nbytes = 2 * $urandom_range(1, 4);
            if ($urandom_range(7) == 0)
               nbytes = nbytes - 1;
            add_read_txn(nbytes);
         end else if (choice < 90) begin
            // broken: address cut short, then reads or more bytes
            add_item(CMD_START_WR, 8'($urandom));
            add_item(CMD_BYTE_WR, 8'($urandom));
            repeat ($urandom_range(1, 3))
               add_item(2'($urandom_range(1, 3)), 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6))
               add_item(2'($urandom), 8'($urandom));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (!timed_out &&
             !(bus_item_q.size() == 0 && !start && read_return_q.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (read_return_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, read_return_q.size());
         err_count++;
      end
      if (timed_out)
         $display("%0t: no handshake or result for %0d cycles", $time, QUIET_LIMIT);

      $display("Drove %0d bus events (%0d directed); checked %0d read bytes.",
               items_taken, directed_items, reads_checked);
      $display("Words committed in range: %0d, writes dropped out of range: %0d.",
               words_stored, words_dropped);
      if (!timed_out && err_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
